// File: design/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while reset is asserted.
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while reset is asserted.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, opcode and status codes, FSM states and the controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;
    localparam int OPC_W   = 2;
    localparam int STAT_W  = 2;

    // Helper widths for zero extension before truncation to a field.
    localparam int VAL_EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int OCC_EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    // Occupancy field value reported for a full queue.
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load_item;
        logic execute;
    } deq_cmd_t;

endpackage

`default_nettype wire

// File: design/deq_datapath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring buffer storage, front/back pointers, count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire deq_pkg::deq_cmd_t             cmd,
    input  wire logic [deq_pkg::OPC_W-1:0]     opcode,
    input  wire logic [deq_pkg::VALUE_W-1:0]   write_value,
    output logic                               success,
    output logic [deq_pkg::STAT_W-1:0]         status,
    output logic [deq_pkg::VALUE_W-1:0]        read_value,
    output logic [deq_pkg::OCC_W-1:0]          occupancy
);
    import deq_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    opcode_t               op_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;
    logic [ADDR_W-1:0]     front_reg, front_next;
    logic [ADDR_W-1:0]     back_reg, back_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic                  success_reg, success_next;
    status_t               status_reg, status_next;
    logic                  pop_ok_reg, pop_ok_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;

    logic [ADDR_W-1:0]     front_up, front_dn, back_up, back_dn;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic                  we, re;
    logic                  full, empty;
    logic [VAL_EXT_W-1:0]  wval_ext, rval_ext;
    logic [OCC_EXT_W-1:0]  occ_ext;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    assign front_up = (front_reg == LAST_SLOT) ? '0 : front_reg + ADDR_W'(1);
    assign front_dn = (front_reg == '0) ? LAST_SLOT : front_reg - ADDR_W'(1);
    assign back_up  = (back_reg == LAST_SLOT) ? '0 : back_reg + ADDR_W'(1);
    assign back_dn  = (back_reg == '0) ? LAST_SLOT : back_reg - ADDR_W'(1);

    assign wval_ext = VAL_EXT_W'(write_value);

    always_comb
    begin
        front_next   = front_reg;
        back_next    = back_reg;
        count_next   = count_reg;
        waddr        = back_reg;
        raddr        = front_reg;
        we           = 1'b0;
        re           = 1'b0;
        success_next = 1'b0;
        status_next  = ST_OK;
        pop_ok_next  = 1'b0;
        case (op_reg)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    waddr        = front_dn;
                    we           = cmd.execute;
                    front_next   = front_dn;
                    count_next   = count_reg + CNT_W'(1);
                    success_next = 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    waddr        = back_reg;
                    we           = cmd.execute;
                    back_next    = back_up;
                    count_next   = count_reg + CNT_W'(1);
                    success_next = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    raddr        = front_reg;
                    re           = cmd.execute;
                    front_next   = front_up;
                    count_next   = count_reg - CNT_W'(1);
                    success_next = 1'b1;
                    pop_ok_next  = 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    raddr        = back_dn;
                    re           = cmd.execute;
                    back_next    = back_dn;
                    count_next   = count_reg - CNT_W'(1);
                    success_next = 1'b1;
                    pop_ok_next  = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        occ_ext  = OCC_EXT_W'(count_next);
        occ_next = occ_ext[OCC_W-1:0];
    end

    // Pointers and count are the queue's control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= opcode_t'(opcode);
            wdata_reg <= wval_ext[DATA_WIDTH-1:0];
        end
        if (cmd.execute)
        begin
            success_reg <= success_next;
            status_reg  <= status_next;
            pop_ok_reg  <= pop_ok_next;
            occ_reg     <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata_reg;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rval_ext   = VAL_EXT_W'(rdata_reg);
    assign success    = success_reg;
    assign status     = status_reg;
    assign read_value = pop_ok_reg ? rval_ext[VALUE_W-1:0] : '0;
    assign occupancy  = occ_reg;

endmodule

`default_nettype wire

// File: design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences load and execute of each transaction and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output deq_pkg::deq_cmd_t  cmd
);
    import deq_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg & out_stall;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // The result register may only be overwritten once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque in a ring buffer with push and pop at either end.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one operation per
// transaction: an opcode (push front, push back, pop front, pop back) and a
// write_value that only pushes use. The output channel (out_valid, out_stall)
// returns exactly one result per operation: a success flag, a status code
// (ok, full on push, empty on pop), the popped value (zero unless a pop
// succeeded) and the occupancy after the operation.
// An operation is accepted in the idle state and executed in the execute
// state, when the ring buffer is written or its registered read port is
// loaded and the result is registered. The controller alternates between
// taking an item and executing it against the single storage write/read
// port, so no new operation is accepted before the last one has executed.
// The output register separates the two sides: a new operation is accepted
// while the previous result still waits; it then holds in execution until
// the receiver takes that result, and in_stall stays high meanwhile.
// Reset clears the pointers, the entry count and the output valid, leaving
// the queue empty; stored entries are not cleared, since a pop only reads
// slots that an earlier push wrote.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [deq_pkg::OPC_W-1:0]     opcode,
    input  wire logic [deq_pkg::VALUE_W-1:0]   write_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               success,
    output logic [deq_pkg::STAT_W-1:0]         status,
    output logic [deq_pkg::VALUE_W-1:0]        read_value,
    output logic [deq_pkg::OCC_W-1:0]          occupancy
);
    import deq_pkg::*;

    // Commands from the controller to the datapath.
    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath latches the operation on load and applies it on execute.
    deq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (opcode),
        .write_value (write_value),
        .success     (success),
        .status      (status),
        .read_value  (read_value),
        .occupancy   (occupancy)
    );

endmodule

`default_nettype wire

// File: design/deq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Checks result consistency and output handshake behavior at the top ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_macros.svh"

module deq_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          success,
    input  wire logic [deq_pkg::STAT_W-1:0]    status,
    input  wire logic [deq_pkg::VALUE_W-1:0]   read_value,
    input  wire logic [deq_pkg::OCC_W-1:0]     occupancy
);
    import deq_pkg::*;

    // A result succeeds exactly when its status reports ok.
    `DEQ_ASSERT_SAME(a_success_status, out_valid, success == (status == ST_OK), "success and status disagree")

    // A failed operation never returns data.
    `DEQ_ASSERT_SAME(a_fail_zero, out_valid && !success, read_value == '0, "failed result carries data")

    // Empty and full reports agree with the occupancy shown.
    `DEQ_ASSERT_SAME(a_status_occ, out_valid && status != ST_OK, (status == ST_EMPTY && occupancy == '0) || (status == ST_FULL && occupancy == OCC_FULL), "status and occupancy disagree")

    // A stalled result stays valid with its data held.
    `DEQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_value), "stalled result changed")

    // After an accepted operation the input stalls while it executes.
    `DEQ_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "input accepted twice in a row")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .success    (success),
    .status     (status),
    .read_value (read_value),
    .occupancy  (occupancy)
);

`default_nettype wire

// File: tb/sv/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push and pop operations at both ends of the deque, predicts every
// result with a ring-buffer model of its own, and compares each returned
// transaction field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module double_ended_queue_tb;

    import deq_pkg::*;

    // ------------------------------------------------------------------------
    // One result transaction as the block should return it.
    // ------------------------------------------------------------------------
    typedef struct {
        logic               success;
        status_t            status;
        logic [VALUE_W-1:0] read_value;
        logic [OCC_W-1:0]   occupancy;
    } deque_result_t;

    // ------------------------------------------------------------------------
    // Deque tracker: keeps its own copy of the ring buffer and pointers,
    // works out the result of every accepted operation and holds those
    // results in order until the block returns them.
    // ------------------------------------------------------------------------
    class deque_tracker;
        logic [DATA_WIDTH-1:0] slots [DEPTH];
        int unsigned           head_slot;   // Slot of the front element.
        int unsigned           tail_slot;   // Slot one past the back element.
        int unsigned           stored;
        deque_result_t         awaited[$];
        int unsigned           failures;
        int unsigned           operations;
        int unsigned           refused_full;
        int unsigned           refused_empty;
        int unsigned           last_entry_pops;

        function void note_operation(opcode_t op, logic [VALUE_W-1:0] value);
            deque_result_t r;
            r.success    = 1'b0;
            r.status     = ST_OK;
            r.read_value = '0;
            operations++;
            if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
            begin
                if (stored >= DEPTH)
                begin
                    r.status = ST_FULL;
                    refused_full++;
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                        slots[head_slot] = DATA_WIDTH'(value);
                    end
                    else
                    begin
                        slots[tail_slot] = DATA_WIDTH'(value);
                        tail_slot = (tail_slot + 1 >= DEPTH) ? 0 : tail_slot + 1;
                    end
                    stored++;
                    r.success = 1'b1;
                end
            end
            else
            begin
                if (stored == 0)
                begin
                    r.status = ST_EMPTY;
                    refused_empty++;
                end
                else
                begin
                    if (stored == 1)
                        last_entry_pops++;
                    if (op == OP_POP_FRONT)
                    begin
                        r.read_value = VALUE_W'(slots[head_slot]);
                        head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
                    end
                    else
                    begin
                        tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
                        r.read_value = VALUE_W'(slots[tail_slot]);
                    end
                    stored--;
                    r.success = 1'b1;
                end
            end
            r.occupancy = OCC_W'(stored);
            awaited.push_back(r);
        endfunction

        function void check_result(logic got_success, logic [STAT_W-1:0] got_status,
                                   logic [VALUE_W-1:0] got_value,
                                   logic [OCC_W-1:0] got_occupancy);
            deque_result_t exp;
            if (awaited.size() == 0)
            begin
                $error("result transaction arrived with no operation outstanding");
                failures++;
                return;
            end
            exp = awaited.pop_front();
            if (got_success !== exp.success)
            begin
                $error("success: expected %0d, got %0d", exp.success, got_success);
                failures++;
            end
            if (got_status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got_status);
                failures++;
            end
            if (got_value !== exp.read_value)
            begin
                $error("read_value: expected 0x%08h, got 0x%08h", exp.read_value, got_value);
                failures++;
            end
            if (got_occupancy !== exp.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", exp.occupancy, got_occupancy);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports.
    // ------------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [OPC_W-1:0]   opcode;
    logic [VALUE_W-1:0] write_value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               success;
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] read_value;
    logic [OCC_W-1:0]   occupancy;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    deque_tracker tracker = new();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    double_ended_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .success     (success),
        .status      (status),
        .read_value  (read_value),
        .occupancy   (occupancy)
    );

    // ------------------------------------------------------------------------
    // Receiver. The stall is redrawn every cycle; it does not look at
    // out_valid, so stalls land on idle cycles and on waiting results alike.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every result transaction is checked at the edge that accepts it. The
    // sampled values are the ones from before the edge, since every driver
    // in this bench and in the block updates through nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(success, status, read_value, occupancy);
    end

    // ------------------------------------------------------------------------
    // Sender. One call offers one operation and returns at the edge that
    // accepts it; the tracker learns of the operation right there, so its
    // count of outstanding results is exact when the driver looks at it.
    // in_valid is only lowered when a gap follows, so it is never lowered
    // and raised again within one time step.
    // ------------------------------------------------------------------------
    task automatic send_op(input opcode_t op, input logic [VALUE_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        write_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_operation(op, value);
    endtask

    // Holds the sender off until every outstanding result has come back.
    // Its wait loop always waits on the clock before it tests, so a following
    // send never overrides the lowered valid within the same step.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.awaited.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned        mode;
        int unsigned        roll;
        int unsigned        sent;
        int unsigned        push_pct;
        opcode_t            op;
        logic [VALUE_W-1:0] value;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        opcode      <= OP_PUSH_FRONT;
        write_value <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back. Pops from an empty queue at both ends.
        send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
        send_op(OP_POP_BACK, 32'hFFFF_FFFF);

        // With a single element stored, either pop must return it.
        send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(OP_POP_BACK, '0);
        send_op(OP_PUSH_BACK, '0);
        send_op(OP_POP_FRONT, '0);

        // Fill from both ends so the front pointer wraps below slot zero,
        // then push into the full queue at each end and pop at each end.
        for (int i = 0; i < DEPTH; i++)
            send_op((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                    (i % 3 == 0) ? 32'hFFFF_FFFF : (32'h8000_0001 >> i) ^ (32'h5A5A_5A5A << i));
        send_op(OP_PUSH_FRONT, 32'h1234_5678);
        send_op(OP_PUSH_BACK, 32'h8765_4321);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_BACK, '0);

        // Random part in three phases: a fast sender into a busy receiver,
        // the reverse, and finally both at full rate. Each phase begins with
        // the sender holding off until the queue of results has drained.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 16 : (phase == 1) ? 71 : 0;
            recv_stall_pct = (phase == 0) ? 71 : (phase == 1) ? 16 : 0;
            wait_for_drain();
            sent = 0;
            while (sent < 210)
            begin
                // Bursts lean toward filling, draining or neither, so the
                // occupancy walks all the way to full and back to empty.
                mode     = $urandom_range(2);
                push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
                repeat ($urandom_range(24, 4))
                begin
                    roll = $urandom_range(99);
                    if (roll < push_pct)
                        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    else
                        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                    roll  = $urandom_range(9);
                    value = (roll == 0) ? '0 : (roll == 1) ? '1 : VALUE_W'($urandom);
                    send_op(op, value);
                    sent++;
                end
            end
        end

        // Let every result come home, then keep watching so the block can
        // show any transaction it should not produce.
        wait_for_drain();
        repeat (8)
            @(posedge clk);
        if (tracker.awaited.size() != 0)
        begin
            $error("%0d results never arrived", tracker.awaited.size());
            tracker.failures++;
        end

        $display("Ran %0d operations at both ends under gaps and stalls on either side.",
                 tracker.operations);
        $display("Refused pushes when full: %0d, refused pops when empty: %0d, pops of a lone entry: %0d.",
                 tracker.refused_full, tracker.refused_empty, tracker.last_entry_pops);
        if (tracker.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
